### rtl/scm_pkg.sv
// Package for the segmented context MMU: sizes, codes, segment entry layout.
// No dependencies; every other file of the block but scm_ram uses it by scoped names.
package scm_pkg;

  localparam int unsigned NUM_CONTEXTS_DEF = 5;
  localparam int unsigned NUM_SEGMENTS     = 128;
  localparam int unsigned SEG_W            = 7;
  localparam int unsigned CTX_W            = 3;
  localparam int unsigned DATA_W           = 12;
  localparam int unsigned WDATA_W          = 16;
  localparam int unsigned ADDR_W           = 24;
  localparam int unsigned OFFSET_W         = 17;
  localparam int unsigned ORIGIN_SHIFT     = 9;
  localparam int unsigned KIND_W           = 3;
  localparam int unsigned CFG_IDX_W        = 2;

  // Segments shared by every context
  localparam logic [SEG_W-1:0] SEG_SHARED_A = 7'd84;
  localparam logic [SEG_W-1:0] SEG_SHARED_B = 7'd126;
  localparam logic [SEG_W-1:0] SEG_SHARED_C = 7'd127;

  localparam logic [ADDR_W-1:0] IO_BASE = 24'hFC0000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_MASK       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IO_CODE         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPECIAL_IO_CODE = 2'd2;

  localparam logic [DATA_W-1:0] TYPE_MASK_RST       = 12'hF00;
  localparam logic [DATA_W-1:0] IO_CODE_RST         = 12'h900;
  localparam logic [DATA_W-1:0] SPECIAL_IO_CODE_RST = 12'hF00;

  localparam logic [1:0] MARK_LIMIT  = 2'b01;
  localparam logic [1:0] MARK_ORIGIN = 2'b10;

  typedef enum logic [KIND_W-1:0] {
    KIND_XLATE     = 3'd0,
    KIND_SEG_WRITE = 3'd1,
    KIND_SETUP_ON  = 3'd2,
    KIND_SETUP_OFF = 3'd3,
    KIND_SEL1_CLR  = 3'd4,
    KIND_SEL1_SET  = 3'd5,
    KIND_SEL2_CLR  = 3'd6,
    KIND_SEL2_SET  = 3'd7
  } kind_e;

  typedef struct packed {
    logic [1:0]        marks;
    logic [DATA_W-1:0] origin;
    logic [DATA_W-1:0] limit;
  } seg_entry_t;

endpackage

### rtl/scm_if.sv
// Channel interfaces of the segmented context MMU: request, response, config write.
// Depends on scm_pkg for field widths.
interface scm_req_if;
  logic                              valid;
  logic                              ready;
  logic [scm_pkg::KIND_W-1:0]        kind;
  logic [scm_pkg::ADDR_W-1:0]        address;
  logic [scm_pkg::WDATA_W-1:0]       write_data;

  modport source (output valid, kind, address, write_data, input ready);
  modport sink   (input valid, kind, address, write_data, output ready);
endinterface

interface scm_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [scm_pkg::ADDR_W-1:0]        physical_address;
  logic                              translated;
  logic                              io_redirect;
  logic [scm_pkg::CTX_W-1:0]         active_context;

  modport source (output valid, physical_address, translated, io_redirect, active_context,
                  input ready);
  modport sink   (input valid, physical_address, translated, io_redirect, active_context,
                  output ready);
endinterface

interface scm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [scm_pkg::CFG_IDX_W-1:0]     index;
  logic [scm_pkg::DATA_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/scm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old word when both ports hit the same address
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/segmented_context_mmu_top.sv
// Segmented context MMU: one request word per clock, one response word per translate
// request. A request is taken into an input stage while the segment RAM row is read;
// from there it is resolved and loaded into the response register once that register
// is free, and the block sustains one request per cycle as long as the response side
// keeps up. The segment table is a 128-row RAM, one row per segment holding
// the entries of all contexts, so a segment write and its mirroring to other contexts is
// one row read-modify-write; a bypass register covers a request that reads the row being
// written. Each row has a valid flag cleared by reset, so the table reads as zero after
// reset with no clearing pass. Configuration writes are taken in any cycle.
// Depends on scm_pkg, scm_if and scm_ram.
module segmented_context_mmu_top #(
  parameter int unsigned NUM_CONTEXTS = scm_pkg::NUM_CONTEXTS_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  scm_req_if.sink   req_i,
  scm_rsp_if.source rsp_o,
  scm_cfg_if.sink   cfg_i
);

  localparam int unsigned ENTRY_W = $bits(scm_pkg::seg_entry_t);
  localparam int unsigned ROW_W   = NUM_CONTEXTS * ENTRY_W;
  localparam int unsigned CTX_W   = scm_pkg::CTX_W;
  localparam int unsigned SEG_W   = scm_pkg::SEG_W;
  localparam int unsigned ADDR_W  = scm_pkg::ADDR_W;
  localparam int unsigned DATA_W  = scm_pkg::DATA_W;
  localparam logic [CTX_W-1:0] LAST_CTX = CTX_W'(NUM_CONTEXTS - 1);
  localparam logic [CTX_W-1:0] CTX_ONE  = CTX_W'(1);

  typedef scm_pkg::seg_entry_t [NUM_CONTEXTS-1:0] row_t;

  // Configuration registers
  logic [DATA_W-1:0] type_mask_q, io_code_q, sio_code_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_mask_q <= scm_pkg::TYPE_MASK_RST;
      io_code_q   <= scm_pkg::IO_CODE_RST;
      sio_code_q  <= scm_pkg::SPECIAL_IO_CODE_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        scm_pkg::CFG_TYPE_MASK:       type_mask_q <= cfg_i.data;
        scm_pkg::CFG_IO_CODE:         io_code_q   <= cfg_i.data;
        scm_pkg::CFG_SPECIAL_IO_CODE: sio_code_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Input stage
  logic                  s1_valid_q;
  scm_pkg::kind_e        s1_kind_q;
  logic [ADDR_W-1:0]     s1_addr_q;
  logic [DATA_W-1:0]     s1_data_q;
  logic                  in_accept, s1_adv, s1_is_xlate, s1_is_write, out_free;
  logic                  out_valid_q;
  logic [SEG_W-1:0]      s1_seg;

  assign in_accept   = req_i.valid && req_i.ready;
  assign s1_is_xlate = (s1_kind_q == scm_pkg::KIND_XLATE);
  assign s1_is_write = (s1_kind_q == scm_pkg::KIND_SEG_WRITE);
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign s1_adv      = s1_valid_q && (!s1_is_xlate || out_free);
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign s1_seg      = s1_addr_q[ADDR_W-1 -: SEG_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_kind_q <= scm_pkg::kind_e'(req_i.kind);
      s1_addr_q <= req_i.address;
      s1_data_q <= req_i.write_data[DATA_W-1:0];
    end
  end

  // Segment table: one row per segment
  logic [ROW_W-1:0]               ram_rdata;
  logic                           ram_we;
  row_t                           row_cur, row_new;
  logic [scm_pkg::NUM_SEGMENTS-1:0] row_valid_q;
  logic                           byp_hit_q;
  row_t                           byp_row_q;

  assign ram_we = s1_adv && s1_is_write;

  scm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (scm_pkg::NUM_SEGMENTS)
  ) u_seg_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_seg),
    .wdata_i (ROW_W'(row_new)),
    .re_i    (in_accept),
    .raddr_i (req_i.address[ADDR_W-1 -: SEG_W]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (byp_hit_q) begin
      row_cur = byp_row_q;
    end else if (row_valid_q[s1_seg]) begin
      row_cur = row_t'(ram_rdata);
    end else begin
      row_cur = '0;
    end
  end

  // Forward a row written at the same edge the next request read it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      byp_hit_q   <= 1'b0;
    end else begin
      if (ram_we) begin
        row_valid_q[s1_seg] <= 1'b1;
      end
      if (in_accept) begin
        byp_hit_q <= ram_we && (req_i.address[ADDR_W-1 -: SEG_W] == s1_seg);
      end else if (s1_adv) begin
        byp_hit_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && ram_we) begin
      byp_row_q <= row_new;
    end
  end

  // Control state
  logic             setup_q, sel1_q, sel2_q, xlate_on_q;
  logic [CTX_W-1:0] cur_ctx_q;
  logic             setup_d, sel1_d, sel2_d;
  logic [CTX_W-1:0] cur_ctx_d, sel_ctx, wr_ctx;

  assign sel_ctx = CTX_W'({sel2_q, sel1_q}) + CTX_ONE;
  assign wr_ctx  = (sel_ctx > LAST_CTX) ? LAST_CTX : sel_ctx;

  always_comb begin
    setup_d = setup_q;
    sel1_d  = sel1_q;
    sel2_d  = sel2_q;
    case (s1_kind_q)
      scm_pkg::KIND_SETUP_ON:  setup_d = 1'b1;
      scm_pkg::KIND_SETUP_OFF: setup_d = 1'b0;
      scm_pkg::KIND_SEL1_CLR:  sel1_d  = 1'b0;
      scm_pkg::KIND_SEL1_SET:  sel1_d  = 1'b1;
      scm_pkg::KIND_SEL2_CLR:  sel2_d  = 1'b0;
      scm_pkg::KIND_SEL2_SET:  sel2_d  = 1'b1;
      default: ;
    endcase
    cur_ctx_d = setup_d ? '0 : CTX_W'({sel2_d, sel1_d}) + CTX_ONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setup_q    <= 1'b1;
      sel1_q     <= 1'b0;
      sel2_q     <= 1'b0;
      xlate_on_q <= 1'b0;
      cur_ctx_q  <= '0;
    end else if (s1_adv && !s1_is_xlate && !s1_is_write) begin
      setup_q    <= setup_d;
      sel1_q     <= sel1_d;
      sel2_q     <= sel2_d;
      xlate_on_q <= 1'b1;
      cur_ctx_q  <= cur_ctx_d;
    end
  end

  // Segment write: update the target entry, then mirror it
  scm_pkg::seg_entry_t wr_entry;
  logic                shared_seg;

  assign shared_seg = (s1_seg == scm_pkg::SEG_SHARED_A) || (s1_seg == scm_pkg::SEG_SHARED_B) ||
                      (s1_seg == scm_pkg::SEG_SHARED_C);

  always_comb begin
    wr_entry = row_cur[wr_ctx];
    if (s1_addr_q[3]) begin
      wr_entry.origin = s1_data_q;
      wr_entry.marks  = wr_entry.marks | scm_pkg::MARK_ORIGIN;
    end else begin
      wr_entry.limit  = s1_data_q;
      wr_entry.marks  = wr_entry.marks | scm_pkg::MARK_LIMIT;
    end
    row_new = row_cur;
    for (int unsigned c = 0; c < NUM_CONTEXTS; c++) begin
      if ((CTX_W'(c) == wr_ctx) || (c == 0 && wr_ctx == CTX_ONE) || shared_seg) begin
        row_new[c] = wr_entry;
      end
    end
  end

  // Translation
  logic [CTX_W-1:0]                 xl_ctx;
  scm_pkg::seg_entry_t              xl_entry;
  logic [DATA_W-1:0]                lim_type;
  logic                             is_io, hit;
  logic [scm_pkg::OFFSET_W-1:0]     offset;
  logic [ADDR_W-1:0]                phys_mapped, phys;

  assign xl_ctx      = (cur_ctx_q > LAST_CTX) ? '0 : cur_ctx_q;
  assign xl_entry    = row_cur[xl_ctx];
  assign lim_type    = xl_entry.limit & type_mask_q;
  assign is_io       = (lim_type == io_code_q) || (lim_type == sio_code_q);
  assign offset      = s1_addr_q[scm_pkg::OFFSET_W-1:0];
  assign phys_mapped = ADDR_W'({xl_entry.origin, {scm_pkg::ORIGIN_SHIFT{1'b0}}}) +
                       ADDR_W'(offset);
  assign hit         = xlate_on_q && (xl_entry.marks != 2'b00);

  always_comb begin
    if (!hit) begin
      phys = s1_addr_q;
    end else if (is_io) begin
      phys = scm_pkg::IO_BASE | ADDR_W'(offset);
    end else begin
      phys = phys_mapped;
    end
  end

  // Response register
  logic [ADDR_W-1:0] out_phys_q;
  logic              out_xl_q, out_io_q;
  logic [CTX_W-1:0]  out_ctx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_is_xlate) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_is_xlate) begin
      out_phys_q <= phys;
      out_xl_q   <= hit;
      out_io_q   <= hit && is_io;
      out_ctx_q  <= xl_ctx;
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.physical_address = out_phys_q;
  assign rsp_o.translated       = out_xl_q;
  assign rsp_o.io_redirect      = out_io_q;
  assign rsp_o.active_context   = out_ctx_q;

endmodule

### rtl/scm_checker.sv
// Port-level checks for the segmented context MMU, bound to the top level.
// Depends on scm_pkg and segmented_context_mmu_top.
module scm_checker #(
  parameter int unsigned NUM_CONTEXTS = scm_pkg::NUM_CONTEXTS_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic [scm_pkg::ADDR_W-1:0]   rsp_phys_i,
  input logic                         rsp_translated_i,
  input logic                         rsp_io_i,
  input logic [scm_pkg::CTX_W-1:0]    rsp_ctx_i
);

  // Hold a stalled response word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_phys_i) &&
      $stable(rsp_translated_i) && $stable(rsp_io_i) && $stable(rsp_ctx_i))
    else $error("response word changed while stalled");

  // I/O redirect only comes from an applied segment entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_io_i |-> rsp_translated_i)
    else $error("io redirect without translation");

  // Redirected addresses land in the I/O window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_io_i |-> rsp_phys_i[23:18] == 6'h3F && !rsp_phys_i[17])
    else $error("io redirect outside io window");

  // Reported context always exists
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_ctx_i <= scm_pkg::CTX_W'(NUM_CONTEXTS - 1))
    else $error("active context out of range");

endmodule

bind segmented_context_mmu_top scm_checker #(
  .NUM_CONTEXTS (NUM_CONTEXTS)
) u_scm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_phys_i       (rsp_o.physical_address),
  .rsp_translated_i (rsp_o.translated),
  .rsp_io_i         (rsp_o.io_redirect),
  .rsp_ctx_i        (rsp_o.active_context)
);
